/* rtl/core/ttps_pkg.sv */
// Shared constants, field positions and action codes of the transposition table probe store.
package ttps_pkg;

    // Default table geometry. The table depth is a power of two.
    localparam int TABLE_ENTRIES_DEF = 65536;
    localparam int SCORE_BITS_DEF    = 16;

    // Fixed field widths of the stream items.
    localparam int ACTION_W = 2;
    localparam int KEY_W    = 64;
    localparam int BOUND_W  = 16;
    localparam int DEPTH_W  = 8;
    localparam int PLY_W    = 8;
    localparam int MOVE_W   = 32;
    localparam int KIND_W   = 2;
    localparam int THR_W    = 15;

    localparam logic [THR_W-1:0] THR_RESET = 15'd31000;

    // Input tdata layout, lowest bit first.
    localparam int KEY_LSB   = 0;
    localparam int ALPHA_LSB = KEY_LSB + KEY_W;
    localparam int BETA_LSB  = ALPHA_LSB + BOUND_W;
    localparam int DEPTH_LSB = BETA_LSB + BOUND_W;
    localparam int PLY_LSB   = DEPTH_LSB + DEPTH_W;
    localparam int SCORE_LSB = PLY_LSB + PLY_W;
    localparam int MOVE_LSB  = SCORE_LSB + BOUND_W;
    localparam int KIND_LSB  = MOVE_LSB + MOVE_W;
    localparam int S_TDATA_W = ((KIND_LSB + KIND_W + 7) / 8) * 8;
    localparam int S_TUSER_W = ACTION_W;

    // Output tdata and tuser layout, lowest bit first.
    localparam int CUT_SCORE_LSB = 0;
    localparam int MOVE_OUT_LSB  = CUT_SCORE_LSB + BOUND_W;
    localparam int M_TDATA_W     = ((MOVE_OUT_LSB + MOVE_W + 7) / 8) * 8;
    localparam int U_CUTOFF      = 0;
    localparam int U_MOVE        = 1;
    localparam int U_DONE        = 2;
    localparam int M_TUSER_W     = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PROBE = 2'd0,
        ACT_STORE = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_EXACT = 2'd0,
        KIND_UPPER = 2'd1,
        KIND_LOWER = 2'd2
    } kind_t;

endpackage

/* rtl/core/ttps_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module ttps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read data holds its value until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/transposition_table_probe_store.sv */
// Top level of the direct-mapped, always-replace transposition table.
//
// Usage: each transfer on the s_ channel carries one action in s_tuser: probe, store or
// clear. Every action gives exactly one result transfer on the m_ channel. The entry is
// chosen by the low key bits; a hit needs the full 64-bit key to match. The user must
// write the mate_threshold register over the cfg_ channel only while the table is idle;
// the block itself does not enforce this.
//
// Flow: an accepted probe or store reads its entry from the table RAM into a register,
// and the lookup state puts its result into the output register once that is free.
// s_tready rises again in the cycle after that, so a new probe or store waits for the
// last one, set by the single read-modify-write pass through the table RAM. A clear
// walks the table one entry per cycle and then answers from the lookup state.
//
// Reset: the state machine, the output register and mate_threshold (31000) are reset.
// The table RAM itself is not initialized; an entry reads valid once stored or cleared.
//
// Stall: a finished result waits in the output register while m_tready is low. A new
// item can still be accepted; it then waits with its read data held until the output
// register is free. No transfer is lost or repeated.
module transposition_table_probe_store #(
    parameter int TABLE_ENTRIES = ttps_pkg::TABLE_ENTRIES_DEF,
    parameter int SCORE_BITS    = ttps_pkg::SCORE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration: mate_threshold.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ttps_pkg::THR_W-1:0]     cfg_data,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: position_key, alpha_bound, beta_bound, search_depth, ply_from_root,
    // store_score, store_move, store_kind, then zero fill.
    input  logic [ttps_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: action.
    input  logic [ttps_pkg::S_TUSER_W-1:0] s_tuser,
    // Output stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: cutoff_score, move_out.
    output logic [ttps_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: cutoff_found, move_found, done_res.
    output logic [ttps_pkg::M_TUSER_W-1:0] m_tuser
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int ENTRY_W = ttps_pkg::KEY_W + ttps_pkg::DEPTH_W + ttps_pkg::KIND_W + SCORE_BITS;
    // Entry layout: score in the low bits, then kind, depth and key.
    localparam int E_KIND_LSB  = SCORE_BITS;
    localparam int E_DEPTH_LSB = E_KIND_LSB + ttps_pkg::KIND_W;
    localparam int E_KEY_LSB   = E_DEPTH_LSB + ttps_pkg::DEPTH_W;
    // Arithmetic width: room for the wider score format plus the ply adjustment.
    localparam int CALC_W = ((SCORE_BITS > ttps_pkg::BOUND_W) ? SCORE_BITS : ttps_pkg::BOUND_W) + 2;
    localparam logic [IDX_W-1:0] CLEAR_LAST = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic signed [CALC_W-1:0] SAT_HI =
        {{(CALC_W - SCORE_BITS + 1){1'b0}}, {(SCORE_BITS - 1){1'b1}}};
    localparam logic signed [CALC_W-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CLEAR
    } state_t;

    state_t                          state_reg, state_next;
    logic [IDX_W-1:0]                clear_index_reg, clear_index_next;
    logic [ttps_pkg::THR_W-1:0]      mate_threshold_reg, mate_threshold_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [ttps_pkg::M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [ttps_pkg::M_TUSER_W-1:0]  m_tuser_reg, m_tuser_next;

    // Item held while its entry is read and processed.
    logic [ttps_pkg::ACTION_W-1:0]   act_reg;
    logic [ttps_pkg::KEY_W-1:0]      key_reg;
    logic [ttps_pkg::BOUND_W-1:0]    alpha_reg;
    logic [ttps_pkg::BOUND_W-1:0]    beta_reg;
    logic [ttps_pkg::DEPTH_W-1:0]    depth_reg;
    logic [ttps_pkg::PLY_W-1:0]      ply_reg;
    logic [ttps_pkg::BOUND_W-1:0]    score_reg;
    logic [ttps_pkg::MOVE_W-1:0]     move_reg;
    logic [ttps_pkg::KIND_W-1:0]     kind_reg;

    logic                            in_xfer;
    logic                            out_free;
    logic                            emit;

    logic                            entry_we;
    logic [IDX_W-1:0]                entry_waddr;
    logic [ENTRY_W-1:0]              entry_wdata;
    logic [ENTRY_W-1:0]              entry_rdata;
    logic                            move_we;
    logic [ttps_pkg::MOVE_W-1:0]     move_rdata;
    logic [IDX_W-1:0]                rd_idx;

    logic signed [CALC_W-1:0]        thr_ext;
    logic signed [CALC_W-1:0]        ply_ext;
    logic signed [CALC_W-1:0]        alpha_ext;
    logic signed [CALC_W-1:0]        beta_ext;
    logic signed [CALC_W-1:0]        stored_score;
    logic signed [CALC_W-1:0]        probe_score;
    logic signed [CALC_W-1:0]        store_adj;
    logic [ENTRY_W-1:0]              store_entry;
    logic                            hit;
    logic                            res_cut;
    logic                            res_move_found;
    logic                            res_done;
    logic [ttps_pkg::BOUND_W-1:0]    res_score;
    logic [ttps_pkg::MOVE_W-1:0]     res_move;

    // Clamp to the signed range of a stored score.
    function automatic logic signed [CALC_W-1:0] sat_score(input logic signed [CALC_W-1:0] v);
        logic signed [CALC_W-1:0] r;
        begin
            r = v;
            if (v > SAT_HI)
            begin
                r = SAT_HI;
            end
            else if (v < SAT_LO)
            begin
                r = SAT_LO;
            end
            return r;
        end
    endfunction

    function automatic logic signed [CALC_W-1:0] sext16(input logic [ttps_pkg::BOUND_W-1:0] v);
        return {{(CALC_W - ttps_pkg::BOUND_W){v[ttps_pkg::BOUND_W-1]}}, v};
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit      = (state_reg == ST_LOOKUP) && out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign rd_idx = s_tdata[ttps_pkg::KEY_LSB +: IDX_W];

    // Key, depth, kind and score live in one RAM so that a clear can sweep them; the
    // moves live in a second RAM that a clear leaves alone.
    ttps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (entry_we),
        .wr_addr (entry_waddr),
        .wr_data (entry_wdata),
        .rd_en   (in_xfer),
        .rd_addr (rd_idx),
        .rd_data (entry_rdata)
    );

    ttps_ram #(
        .WIDTH (ttps_pkg::MOVE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_move_ram (
        .clk     (clk),
        .wr_en   (move_we),
        .wr_addr (key_reg[IDX_W-1:0]),
        .wr_data (move_reg),
        .rd_en   (in_xfer),
        .rd_addr (rd_idx),
        .rd_data (move_rdata)
    );

    // Probe evaluation and store preparation on the held item and the read entry.
    always_comb
    begin
        thr_ext      = {{(CALC_W - ttps_pkg::THR_W){1'b0}}, mate_threshold_reg};
        ply_ext      = {{(CALC_W - ttps_pkg::PLY_W){1'b0}}, ply_reg};
        alpha_ext    = sext16(alpha_reg);
        beta_ext     = sext16(beta_reg);
        stored_score = {{(CALC_W - SCORE_BITS){entry_rdata[SCORE_BITS-1]}},
                        entry_rdata[SCORE_BITS-1:0]};

        // Undo the mate-distance adjustment. The second test sees the result of the
        // first, which can matter only when the ply exceeds twice the threshold.
        probe_score = stored_score;
        if (probe_score < -thr_ext)
        begin
            probe_score = probe_score + ply_ext;
        end
        if (probe_score > thr_ext)
        begin
            probe_score = probe_score - ply_ext;
        end
        probe_score = sat_score(probe_score);

        store_adj = sext16(score_reg);
        if (store_adj < -thr_ext)
        begin
            store_adj = store_adj - ply_ext;
        end
        if (store_adj > thr_ext)
        begin
            store_adj = store_adj + ply_ext;
        end
        store_adj = sat_score(store_adj);

        store_entry = '0;
        store_entry[SCORE_BITS-1:0]                      = store_adj[SCORE_BITS-1:0];
        store_entry[E_KIND_LSB +: ttps_pkg::KIND_W]      = kind_reg;
        store_entry[E_DEPTH_LSB +: ttps_pkg::DEPTH_W]    = depth_reg;
        store_entry[E_KEY_LSB +: ttps_pkg::KEY_W]        = key_reg;

        hit            = (entry_rdata[E_KEY_LSB +: ttps_pkg::KEY_W] == key_reg);
        res_cut        = 1'b0;
        res_move_found = 1'b0;
        res_done       = 1'b0;
        res_score      = '0;
        res_move       = '0;

        case (act_reg)
            ttps_pkg::ACT_PROBE:
            begin
                res_done = 1'b1;
                if (hit)
                begin
                    if (entry_rdata[E_DEPTH_LSB +: ttps_pkg::DEPTH_W] >= depth_reg)
                    begin
                        case (entry_rdata[E_KIND_LSB +: ttps_pkg::KIND_W])
                            ttps_pkg::KIND_EXACT:
                            begin
                                res_cut   = 1'b1;
                                res_score = probe_score[ttps_pkg::BOUND_W-1:0];
                            end
                            ttps_pkg::KIND_UPPER:
                            begin
                                if (probe_score <= alpha_ext)
                                begin
                                    res_cut   = 1'b1;
                                    res_score = alpha_reg;
                                end
                            end
                            ttps_pkg::KIND_LOWER:
                            begin
                                if (probe_score >= beta_ext)
                                begin
                                    res_cut   = 1'b1;
                                    res_score = beta_reg;
                                end
                            end
                            default:
                            begin
                                res_cut = 1'b0;
                            end
                        endcase
                    end
                    if (!res_cut)
                    begin
                        res_move_found = 1'b1;
                        res_move       = move_rdata;
                    end
                end
            end
            ttps_pkg::ACT_STORE, ttps_pkg::ACT_CLEAR:
            begin
                res_done = 1'b1;
            end
            default:
            begin
                // The unused action code changes nothing and reports all zeros.
                res_done = 1'b0;
            end
        endcase
    end

    // Table writes: the clear sweep owns the entry RAM while it runs; a store writes
    // both RAMs when its result leaves for the output register.
    always_comb
    begin
        move_we = emit && (act_reg == ttps_pkg::ACT_STORE);
        if (state_reg == ST_CLEAR)
        begin
            entry_we    = 1'b1;
            entry_waddr = clear_index_reg;
            entry_wdata = '0;
        end
        else
        begin
            entry_we    = move_we;
            entry_waddr = key_reg[IDX_W-1:0];
            entry_wdata = store_entry;
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        clear_index_next    = clear_index_reg;
        mate_threshold_next = mate_threshold_reg;
        m_tvalid_next       = m_tvalid_reg && !m_tready;
        m_tdata_next        = m_tdata_reg;
        m_tuser_next        = m_tuser_reg;

        if (cfg_valid && cfg_ready)
        begin
            mate_threshold_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_tuser == ttps_pkg::ACT_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_CLEAR:
            begin
                clear_index_next = clear_index_reg + 1'b1;
                if (clear_index_reg == CLEAR_LAST)
                begin
                    clear_index_next = '0;
                    state_next       = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[ttps_pkg::CUT_SCORE_LSB +: ttps_pkg::BOUND_W] = res_score;
                    m_tdata_next[ttps_pkg::MOVE_OUT_LSB +: ttps_pkg::MOVE_W]   = res_move;
                    m_tuser_next                     = '0;
                    m_tuser_next[ttps_pkg::U_CUTOFF] = res_cut;
                    m_tuser_next[ttps_pkg::U_MOVE]   = res_move_found;
                    m_tuser_next[ttps_pkg::U_DONE]   = res_done;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            clear_index_reg    <= '0;
            mate_threshold_reg <= ttps_pkg::THR_RESET;
            m_tvalid_reg       <= 1'b0;
            m_tdata_reg        <= '0;
            m_tuser_reg        <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            clear_index_reg    <= clear_index_next;
            mate_threshold_reg <= mate_threshold_next;
            m_tvalid_reg       <= m_tvalid_next;
            m_tdata_reg        <= m_tdata_next;
            m_tuser_reg        <= m_tuser_next;
        end
    end

    // Item capture on each accepted input transfer.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            act_reg   <= s_tuser;
            key_reg   <= s_tdata[ttps_pkg::KEY_LSB +: ttps_pkg::KEY_W];
            alpha_reg <= s_tdata[ttps_pkg::ALPHA_LSB +: ttps_pkg::BOUND_W];
            beta_reg  <= s_tdata[ttps_pkg::BETA_LSB +: ttps_pkg::BOUND_W];
            depth_reg <= s_tdata[ttps_pkg::DEPTH_LSB +: ttps_pkg::DEPTH_W];
            ply_reg   <= s_tdata[ttps_pkg::PLY_LSB +: ttps_pkg::PLY_W];
            score_reg <= s_tdata[ttps_pkg::SCORE_LSB +: ttps_pkg::BOUND_W];
            move_reg  <= s_tdata[ttps_pkg::MOVE_LSB +: ttps_pkg::MOVE_W];
            kind_reg  <= s_tdata[ttps_pkg::KIND_LSB +: ttps_pkg::KIND_W];
        end
    end

endmodule

/* rtl/core/ttps_checker.sv */
// Port-level checker for the transposition table probe store, bound to the top level.
module ttps_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ttps_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [ttps_pkg::M_TUSER_W-1:0] m_tuser
);

    // One item at a time: input is refused in the cycle after a transfer.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item was in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_cut_xor_move: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[ttps_pkg::U_CUTOFF] && m_tuser[ttps_pkg::U_MOVE]))
        else $error("cutoff and move reported together");

    a_move_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[ttps_pkg::U_MOVE]
            |-> m_tdata[ttps_pkg::MOVE_OUT_LSB +: ttps_pkg::MOVE_W] == '0)
        else $error("move data nonzero without a move");

    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[ttps_pkg::U_CUTOFF] || m_tuser[ttps_pkg::U_MOVE])
            |-> m_tuser[ttps_pkg::U_DONE])
        else $error("probe result without done");

endmodule

bind transposition_table_probe_store ttps_checker u_ttps_checker (.*);

/* dv/tb.sv */
// Self-checking testbench for the transposition table probe store.
`timescale 1ns / 100ps

module tb;

    localparam int TABLE_ENTRIES = ttps_pkg::TABLE_ENTRIES_DEF;
    localparam int SCORE_BITS    = ttps_pkg::SCORE_BITS_DEF;

    // The action code and the bound kind that the package leaves unnamed.
    localparam logic [ttps_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [ttps_pkg::KIND_W-1:0]   KIND_ODD   = 2'd3;

    // A clear walks all entries, so the limit leaves room for a few of them on top of
    // the slowest stalled traffic.
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 20;
    localparam int POOL_MAX    = 48;

    // One request as it travels on the input stream.
    typedef struct packed {
        logic [ttps_pkg::ACTION_W-1:0] act;
        logic [ttps_pkg::KEY_W-1:0]    key;
        logic [ttps_pkg::BOUND_W-1:0]  alpha;
        logic [ttps_pkg::BOUND_W-1:0]  beta;
        logic [ttps_pkg::DEPTH_W-1:0]  depth;
        logic [ttps_pkg::PLY_W-1:0]    ply;
        logic [ttps_pkg::BOUND_W-1:0]  score;
        logic [ttps_pkg::MOVE_W-1:0]   move;
        logic [ttps_pkg::KIND_W-1:0]   kind;
    } tt_req_t;

    // One table slot as the shadow copy keeps it.
    typedef struct packed {
        logic [ttps_pkg::KEY_W-1:0]   key;
        logic [ttps_pkg::DEPTH_W-1:0] depth;
        logic [ttps_pkg::KIND_W-1:0]  kind;
        logic [SCORE_BITS-1:0]        score;
        logic [ttps_pkg::MOVE_W-1:0]  move;
    } tt_slot_t;

    // One answer of the block, field by field.
    typedef struct packed {
        logic                         cut;
        logic [ttps_pkg::BOUND_W-1:0] cscore;
        logic                         mv;
        logic [ttps_pkg::MOVE_W-1:0]  mout;
        logic                         done;
    } outcome_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [ttps_pkg::THR_W-1:0]     cfg_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [ttps_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [ttps_pkg::S_TUSER_W-1:0] s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [ttps_pkg::M_TDATA_W-1:0] m_tdata;
    logic [ttps_pkg::M_TUSER_W-1:0] m_tuser;

    // Shadow of the table contents. Slots that were never written read as zero, which
    // matches a cleared slot; nothing is probed before the first clear.
    tt_slot_t    tt_shadow [int unsigned];
    int          mate_thr = int'(ttps_pkg::THR_RESET);
    outcome_t    pending_outcomes [$];
    logic [63:0] key_pool [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int clears_left    = 2;
    int err_count      = 0;
    int cycle_count    = 0;

    transposition_table_probe_store u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // The run is cut off if the block stops answering.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The receiver stalls at random, at the rate of the current traffic phase.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int clamp_score(input int v);
        int hi;
        int lo;
        hi = (1 << (SCORE_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Works out the answer to one accepted request and updates the shadow table.
    function automatic outcome_t predict_outcome(input tt_req_t r);
        outcome_t    o;
        tt_slot_t    e;
        int unsigned slot;
        int          s;
        o = '0;
        slot = int'(r.key % 64'(TABLE_ENTRIES));
        if (r.act == ttps_pkg::ACT_PROBE)
        begin
            o.done = 1'b1;
            e = tt_shadow.exists(slot) ? tt_shadow[slot] : '0;
            if (e.key == r.key)
            begin
                if (e.depth >= r.depth)
                begin
                    // Mate scores were stored relative to the node; bring them back
                    // to the distance from the root of this probe.
                    s = int'($signed(e.score));
                    if (s < -mate_thr)
                        s = s + int'(r.ply);
                    if (s > mate_thr)
                        s = s - int'(r.ply);
                    s = clamp_score(s);
                    if (e.kind == ttps_pkg::KIND_EXACT)
                    begin
                        o.cut = 1'b1;
                        o.cscore = s[ttps_pkg::BOUND_W-1:0];
                    end
                    else if (e.kind == ttps_pkg::KIND_UPPER && s <= int'($signed(r.alpha)))
                    begin
                        o.cut = 1'b1;
                        o.cscore = r.alpha;
                    end
                    else if (e.kind == ttps_pkg::KIND_LOWER && s >= int'($signed(r.beta)))
                    begin
                        o.cut = 1'b1;
                        o.cscore = r.beta;
                    end
                end
                if (!o.cut)
                begin
                    o.mv = 1'b1;
                    o.mout = e.move;
                end
            end
        end
        else if (r.act == ttps_pkg::ACT_STORE)
        begin
            s = int'($signed(r.score));
            if (s < -mate_thr)
                s = s - int'(r.ply);
            if (s > mate_thr)
                s = s + int'(r.ply);
            s = clamp_score(s);
            e.key = r.key;
            e.depth = r.depth;
            e.kind = r.kind;
            e.score = s[SCORE_BITS-1:0];
            e.move = r.move;
            tt_shadow[slot] = e;
            o.done = 1'b1;
        end
        else if (r.act == ttps_pkg::ACT_CLEAR)
        begin
            // A clear leaves the stored moves in place.
            foreach (tt_shadow[i])
            begin
                tt_shadow[i].key = '0;
                tt_shadow[i].depth = '0;
                tt_shadow[i].kind = ttps_pkg::KIND_EXACT;
                tt_shadow[i].score = '0;
            end
            o.done = 1'b1;
        end
        return o;
    endfunction

    function automatic tt_req_t make_req(input logic [ttps_pkg::ACTION_W-1:0] act,
                                         input logic [ttps_pkg::KEY_W-1:0] key,
                                         input int alpha, input int beta,
                                         input int depth, input int ply,
                                         input int score,
                                         input logic [ttps_pkg::MOVE_W-1:0] move,
                                         input logic [ttps_pkg::KIND_W-1:0] kind);
        tt_req_t r;
        r.act = act;
        r.key = key;
        r.alpha = alpha[ttps_pkg::BOUND_W-1:0];
        r.beta = beta[ttps_pkg::BOUND_W-1:0];
        r.depth = depth[ttps_pkg::DEPTH_W-1:0];
        r.ply = ply[ttps_pkg::PLY_W-1:0];
        r.score = score[ttps_pkg::BOUND_W-1:0];
        r.move = move;
        r.kind = kind;
        return r;
    endfunction

    // Scores cluster near zero and near both mate thresholds, where the bound tests and
    // the ply adjustment decide the outcome; the rest span the whole field.
    function automatic logic [ttps_pkg::BOUND_W-1:0] pick_score();
        int v;
        case ($urandom_range(3))
            0: v = int'($urandom_range(400)) - 200;
            1: v = mate_thr + int'($urandom_range(400)) - 100;
            2: v = -mate_thr - int'($urandom_range(400)) + 100;
            default: v = int'($urandom_range(65535)) - 32768;
        endcase
        v = clamp_score(v);
        return v[ttps_pkg::BOUND_W-1:0];
    endfunction

    function automatic logic [ttps_pkg::KEY_W-1:0] pool_key();
        return key_pool[$urandom_range(key_pool.size() - 1)];
    endfunction

    // Mostly stores and probes of keys that are likely to be in the table, so that the
    // depth, bound and mate paths are reached; some misses, rare clears and a few items
    // with the unused action code.
    function automatic tt_req_t rand_req();
        tt_req_t r;
        int      pick;
        r.key = {$urandom, $urandom};
        r.alpha = pick_score();
        r.beta = pick_score();
        r.depth = ttps_pkg::DEPTH_W'($urandom_range(255));
        r.ply = ttps_pkg::PLY_W'($urandom_range(255));
        r.score = pick_score();
        r.move = $urandom;
        r.kind = ($urandom_range(9) == 0) ? KIND_ODD
                                          : ttps_pkg::KIND_W'($urandom_range(2));
        pick = $urandom_range(99);
        if (pick < 2 && clears_left > 0)
        begin
            r.act = ttps_pkg::ACT_CLEAR;
            clears_left--;
        end
        else if (pick < 5)
        begin
            r.act = ACT_UNUSED;
        end
        else if (pick < 45)
        begin
            r.act = ttps_pkg::ACT_STORE;
            case ($urandom_range(3))
                // Crowd a few low slots so that keys evict each other.
                0: r.key[15:0] = 16'($urandom_range(63));
                1: if (key_pool.size() != 0) r.key = pool_key();
                2: if (key_pool.size() != 0) r.key[15:0] = 16'(pool_key());
                default: ;
            endcase
            key_pool.push_back(r.key);
            if (key_pool.size() > POOL_MAX)
                void'(key_pool.pop_front());
        end
        else
        begin
            r.act = ttps_pkg::ACT_PROBE;
            if ($urandom_range(1) == 0)
                r.depth = ttps_pkg::DEPTH_W'($urandom_range(32));
            pick = $urandom_range(9);
            if (pick < 6 && key_pool.size() != 0)
                r.key = pool_key();
            else if (pick < 7 && key_pool.size() != 0)
                r.key[15:0] = 16'(pool_key());
            else if (pick < 8)
                r.key = '0;
        end
        return r;
    endfunction

    // Presents one request and waits for its transfer. The valid stays high after the
    // transfer so that back-to-back requests need no second assignment in one step.
    task automatic send_action(input tt_req_t r);
        logic [ttps_pkg::S_TDATA_W-1:0] d;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        d = '0;
        d[ttps_pkg::KEY_LSB +: ttps_pkg::KEY_W] = r.key;
        d[ttps_pkg::ALPHA_LSB +: ttps_pkg::BOUND_W] = r.alpha;
        d[ttps_pkg::BETA_LSB +: ttps_pkg::BOUND_W] = r.beta;
        d[ttps_pkg::DEPTH_LSB +: ttps_pkg::DEPTH_W] = r.depth;
        d[ttps_pkg::PLY_LSB +: ttps_pkg::PLY_W] = r.ply;
        d[ttps_pkg::SCORE_LSB +: ttps_pkg::BOUND_W] = r.score;
        d[ttps_pkg::MOVE_LSB +: ttps_pkg::MOVE_W] = r.move;
        d[ttps_pkg::KIND_LSB +: ttps_pkg::KIND_W] = r.kind;
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= r.act;
        do
            @(posedge clk);
        while (!s_tready);
        pending_outcomes.push_back(predict_outcome(r));
    endtask

    // Holds the input back until every expected answer has arrived. At least one edge
    // passes, so the valid is never lowered and raised in the same step.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_outcomes.size() != 0);
    endtask

    task automatic write_mate_threshold(input logic [ttps_pkg::THR_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mate_thr = int'(v);
    endtask

    task automatic note_error(input string msg);
        if (err_count < 10)
            $display("ERROR: %s", msg);
        err_count++;
    endtask

    // Every result transfer is checked against the oldest expected answer.
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.cut = m_tuser[ttps_pkg::U_CUTOFF];
            got.mv = m_tuser[ttps_pkg::U_MOVE];
            got.done = m_tuser[ttps_pkg::U_DONE];
            got.cscore = m_tdata[ttps_pkg::CUT_SCORE_LSB +: ttps_pkg::BOUND_W];
            got.mout = m_tdata[ttps_pkg::MOVE_OUT_LSB +: ttps_pkg::MOVE_W];
            if (pending_outcomes.size() == 0)
            begin
                note_error($sformatf("result with no request waiting: %p", got));
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (got.cut !== want.cut || got.cscore !== want.cscore ||
                    got.mv !== want.mv || got.mout !== want.mout ||
                    got.done !== want.done)
                begin
                    note_error($sformatf({"cutoff %b/%b score %0d/%0d move_found %b/%b ",
                        "move %h/%h done %b/%b (expected/actual)"},
                        want.cut, got.cut, $signed(want.cscore), $signed(got.cscore),
                        want.mv, got.mv, want.mout, got.mout, want.done, got.done));
                end
            end
        end
    end

    // Hand-picked cases at the reset threshold: the cleared slot, score saturation,
    // each bound kind on both sides of its test, too little depth, key mismatch in the
    // same slot, the odd kind and the unused action.
    task automatic test_directed_cases();
        localparam logic [63:0] K0 = 64'hFEDC_BA98_7654_0000;
        localparam logic [63:0] K1 = 64'h0000_0000_0000_FFFF;
        localparam logic [63:0] K2 = 64'h8000_0000_0000_1234;
        localparam logic [63:0] K3 = 64'h7FFF_FFFF_FFFF_0042;
        localparam logic [63:0] K4 = 64'h0123_4567_89AB_0077;
        localparam logic [63:0] K5 = 64'hAAAA_5555_AAAA_5555;
        send_action(make_req(ttps_pkg::ACT_CLEAR, '0, 0, 0, 0, 0, 0, '0,
                             ttps_pkg::KIND_EXACT));
        // Key zero hits the cleared slot with an exact score of zero.
        send_action(make_req(ttps_pkg::ACT_PROBE, '0, 0, 0, 0, 0, 0, '0,
                             ttps_pkg::KIND_EXACT));
        // Slot zero gets a real move so that later probes of key zero are defined.
        send_action(make_req(ttps_pkg::ACT_STORE, K0, 0, 0, 255, 5, 32767, 32'hFFFF_FFFF,
                             ttps_pkg::KIND_EXACT));
        send_action(make_req(ttps_pkg::ACT_PROBE, K0, 0, 0, 255, 0, 0, '0,
                             ttps_pkg::KIND_EXACT));
        send_action(make_req(ttps_pkg::ACT_PROBE, K0, -32768, 32767, 0, 255, 0, '0,
                             ttps_pkg::KIND_EXACT));
        send_action(make_req(ttps_pkg::ACT_PROBE, '0, 0, 0, 200, 0, 0, '0,
                             ttps_pkg::KIND_EXACT));
        send_action(make_req(ttps_pkg::ACT_STORE, K1, 0, 0, 10, 255, -32768, 32'h1234_5678,
                             ttps_pkg::KIND_UPPER));
        send_action(make_req(ttps_pkg::ACT_PROBE, K1, -32768, 0, 10, 0, 0, '0,
                             ttps_pkg::KIND_EXACT));
        send_action(make_req(ttps_pkg::ACT_PROBE, K1, -32768, 0, 10, 200, 0, '0,
                             ttps_pkg::KIND_EXACT));
        send_action(make_req(ttps_pkg::ACT_PROBE, K1, 32767, 0, 11, 0, 0, '0,
                             ttps_pkg::KIND_EXACT));
        send_action(make_req(ttps_pkg::ACT_STORE, K2, 0, 0, 0, 0, 100, 32'hA5A5_5A5A,
                             ttps_pkg::KIND_LOWER));
        send_action(make_req(ttps_pkg::ACT_PROBE, K2, 0, 100, 0, 0, 0, '0,
                             ttps_pkg::KIND_EXACT));
        send_action(make_req(ttps_pkg::ACT_PROBE, K2, 0, 101, 0, 0, 0, '0,
                             ttps_pkg::KIND_EXACT));
        send_action(make_req(ttps_pkg::ACT_PROBE, {1'b0, K2[62:0]}, 0, 0, 0, 0, 0, '0,
                             ttps_pkg::KIND_EXACT));
        send_action(make_req(ttps_pkg::ACT_STORE, K3, 0, 0, 255, 0, 0, 32'h8000_0001,
                             KIND_ODD));
        send_action(make_req(ttps_pkg::ACT_PROBE, K3, 32767, -32768, 0, 0, 0, '0,
                             ttps_pkg::KIND_EXACT));
        send_action(make_req(ACT_UNUSED, K3, -1, -1, 255, 255, -1, 32'hFFFF_FFFF, KIND_ODD));
        send_action(make_req(ttps_pkg::ACT_STORE, K4, 0, 0, 3, 100, -31001, 32'h0000_0001,
                             ttps_pkg::KIND_EXACT));
        send_action(make_req(ttps_pkg::ACT_PROBE, K4, 0, 0, 3, 100, 0, '0,
                             ttps_pkg::KIND_EXACT));
        send_action(make_req(ttps_pkg::ACT_STORE, K5, 0, 0, 128, 255, 31001, 32'h7FFF_FFFE,
                             ttps_pkg::KIND_EXACT));
        send_action(make_req(ttps_pkg::ACT_PROBE, K5, 0, 0, 128, 0, 0, '0,
                             ttps_pkg::KIND_EXACT));
    endtask

    // The threshold moves through both extremes and a random value, then back to its
    // reset value; it is only written once the table has answered everything.
    task automatic test_threshold_sweep();
        logic [ttps_pkg::THR_W-1:0] settings [4];
        settings[0] = '0;
        settings[1] = '1;
        settings[2] = ttps_pkg::THR_W'($urandom_range(32767));
        settings[3] = ttps_pkg::THR_RESET;
        foreach (settings[i])
        begin
            wait_drained();
            write_mate_threshold(settings[i]);
            repeat (15)
                send_action(rand_req());
        end
    endtask

    // One phase of random traffic. Halfway through, the sender holds back until the
    // block has answered everything.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int count);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                wait_drained();
            send_action(rand_req());
        end
    endtask

    initial
    begin
        send_idle_pct = 10;
        recv_stall_pct = 86;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_threshold_sweep();
        test_random_traffic(10, 86, 110);
        test_random_traffic(86, 10, 110);
        test_random_traffic(0, 0, 110);
        wait_drained();
        // A few more edges catch any answer that nobody asked for.
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/ttps_pkg.sv
rtl/core/ttps_ram.sv
rtl/core/transposition_table_probe_store.sv
rtl/core/ttps_checker.sv
dv/tb.sv
